// File: hdl/dlgl_pkg.sv
`default_nettype none

package dlgl_pkg;

  localparam int MAX_DIGITS   = 32;
  localparam int GW_BITS      = 6;
  localparam int NUM_GLYPHS   = 10;
  localparam int NUM_BITS     = 32;
  localparam int BCD_DIGITS   = 10;
  localparam int SRCX_BITS    = 10;
  localparam int CELL_BITS    = 15;
  localparam int COUNT_BITS   = 6;
  localparam int DIV_BITS     = 21;
  localparam int DIVISOR_BITS = 6;
  localparam int POS_BITS     = 17;
  localparam int WIDTHS_BITS  = 60;

  localparam logic [WIDTHS_BITS-1:0] WIDTHS_RESET = 60'd146402730743726600;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CHECK,
    S_DIVC,
    S_PREP,
    S_DIVW,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: hdl/dlgl_div.sv
`default_nettype none

module dlgl_div (
  input  wire logic                                  clk,
  input  wire logic                                  load,
  input  wire logic                                  step,
  input  wire logic [dlgl_pkg::DIV_BITS-1:0]         dividend,
  input  wire logic [dlgl_pkg::DIVISOR_BITS-1:0]     divisor,
  output logic      [dlgl_pkg::DIV_BITS-1:0]         quot
);

  logic [dlgl_pkg::DIVISOR_BITS-1:0] rem;
  logic [dlgl_pkg::DIVISOR_BITS:0]   trial;
  logic                              fits;

  // One quotient bit per cycle while step is high, restoring division.
  always_comb begin
    trial = {rem, quot[dlgl_pkg::DIV_BITS-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= dividend;
      rem  <= '0;
    end else if (step) begin
      quot <= {quot[dlgl_pkg::DIV_BITS-2:0], fits};
      if (fits) begin
        rem <= dlgl_pkg::DIVISOR_BITS'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[dlgl_pkg::DIVISOR_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/decimal_number_glyph_layout_unit.sv
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+------------------------------------
// input    | s_axis_tvalid / s_axis_tready   | s_axis_tdata: number and rectangle
// output   | m_axis_tvalid / m_axis_tready   | m_axis_tdata: one blit, m_axis_tlast
// config   | cfg_valid / cfg_ready           | cfg_data: packed glyph widths
//
// One number at a time: bit-serial binary to BCD conversion, a check state, the
// cell-width divider, a setup state, the ten glyph-scaling dividers, then one blit per
// digit; an invalid rectangle, a zero digit count or a zero cell width ends it with no blits.
// Reset is synchronous and restores the default glyph widths of 8.
// The output register lets a new number be taken while the last blit still waits;
// a stalled output holds the digit sequencer.
`default_nettype none

module decimal_number_glyph_layout_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // number, min_digits, rect_x, rect_y, rect_w, rect_h, color, zero pad
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // src_x, src_w, dst_x, dst_y, dst_w, dst_h, blit_color, zero pad
  output logic      [111:0] m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  // glyph widths of digits 0 to 9, digit 0 lowest
  input  wire logic [59:0]  cfg_data
);

  dlgl_pkg::state_t state, state_next;

  logic [dlgl_pkg::WIDTHS_BITS-1:0]  widths;
  logic [dlgl_pkg::NUM_BITS-1:0]     nsr;
  logic [4*dlgl_pkg::BCD_DIGITS-1:0] bcd;
  logic [4*dlgl_pkg::BCD_DIGITS-1:0] bcd_adj;
  logic [dlgl_pkg::COUNT_BITS-1:0]   mind;
  logic [15:0]                       rx, ry, rw, rh;
  logic [31:0]                       col;
  logic [dlgl_pkg::SRCX_BITS-1:0]    offs [dlgl_pkg::NUM_GLYPHS];
  logic [dlgl_pkg::SRCX_BITS-1:0]    acc;
  logic [dlgl_pkg::GW_BITS-1:0]      adv;
  logic [4:0]                        cnt;
  logic [dlgl_pkg::COUNT_BITS-1:0]   count, count_next, remain;
  logic [dlgl_pkg::COUNT_BITS-1:0]   sig, mind_sat;
  logic [dlgl_pkg::CELL_BITS-1:0]    cell_w, cell_q;
  logic [dlgl_pkg::POS_BITS-1:0]     left;
  logic                              rect_ok, emit_load;

  logic [dlgl_pkg::GW_BITS-1:0]      gw [dlgl_pkg::NUM_GLYPHS];
  logic [3:0]                        gw_addr, digit;
  logic [dlgl_pkg::GW_BITS-1:0]      gw_sel;
  logic [dlgl_pkg::DIV_BITS-1:0]     cell_quot;
  logic [dlgl_pkg::DIV_BITS-1:0]     lane_prod [dlgl_pkg::NUM_GLYPHS];
  logic [dlgl_pkg::DIV_BITS-1:0]     lane_quot [dlgl_pkg::NUM_GLYPHS];
  logic [dlgl_pkg::CELL_BITS-1:0]    dw_sel, spare;
  logic [dlgl_pkg::DIV_BITS-1:0]     left_off;

  logic [dlgl_pkg::SRCX_BITS-1:0]    o_src_x;
  logic [dlgl_pkg::GW_BITS-1:0]      o_src_w;
  logic [dlgl_pkg::POS_BITS-1:0]     o_dst_x;
  logic [15:0]                       o_dst_y;
  logic [dlgl_pkg::CELL_BITS-1:0]    o_dst_w, o_dst_h;
  logic [31:0]                       o_color;
  logic                              o_last, o_valid;

  assign s_axis_tready = (state == dlgl_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {1'b0, o_color, o_dst_h, o_dst_w, o_dst_y, o_dst_x, o_src_w, o_src_x};

  assign digit     = bcd[3:0];
  assign gw_addr   = (state == dlgl_pkg::S_CONV) ? cnt[3:0] : digit;
  assign gw_sel    = gw[gw_addr];
  assign cell_q    = cell_quot[dlgl_pkg::CELL_BITS-1:0];
  assign emit_load = (state == dlgl_pkg::S_EMIT) && (!o_valid || m_axis_tready);

  always_comb begin
    for (int i = 0; i < dlgl_pkg::NUM_GLYPHS; i++) begin
      gw[i]        = widths[i*dlgl_pkg::GW_BITS +: dlgl_pkg::GW_BITS];
      lane_prod[i] = dlgl_pkg::DIV_BITS'(gw[i]) * dlgl_pkg::DIV_BITS'(cell_q);
    end
  end

  always_comb begin
    for (int i = 0; i < dlgl_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    sig = '0;
    for (int i = 0; i < dlgl_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        sig = dlgl_pkg::COUNT_BITS'(i + 1);
      end
    end
    mind_sat   = (mind > dlgl_pkg::COUNT_BITS'(dlgl_pkg::MAX_DIGITS)) ?
                 dlgl_pkg::COUNT_BITS'(dlgl_pkg::MAX_DIGITS) : mind;
    count_next = (sig < mind_sat) ? mind_sat : sig;
    rect_ok    = !rw[15] && (rw != 16'd0) && !rh[15] && (rh != 16'd0);
  end

  assign dw_sel   = (adv == '0) ? '0 : lane_quot[digit][dlgl_pkg::CELL_BITS-1:0];
  assign spare    = dlgl_pkg::CELL_BITS'(cell_w - dw_sel);
  assign left_off = dlgl_pkg::DIV_BITS'(count - 1'b1) * dlgl_pkg::DIV_BITS'(cell_w);

  dlgl_div u_cell_div (
    .clk      (clk),
    .load     (state == dlgl_pkg::S_CHECK),
    .step     (state == dlgl_pkg::S_DIVC),
    .dividend (dlgl_pkg::DIV_BITS'(rw[dlgl_pkg::CELL_BITS-1:0])),
    .divisor  (count),
    .quot     (cell_quot)
  );

  for (genvar g = 0; g < dlgl_pkg::NUM_GLYPHS; g++) begin : g_lane
    dlgl_div u_lane_div (
      .clk      (clk),
      .load     (state == dlgl_pkg::S_PREP),
      .step     (state == dlgl_pkg::S_DIVW),
      .dividend (lane_prod[g]),
      .divisor  (adv),
      .quot     (lane_quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlgl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dlgl_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = dlgl_pkg::S_CONV;
        end
      end
      dlgl_pkg::S_CONV: begin
        if (cnt == 5'(dlgl_pkg::NUM_BITS - 1)) begin
          state_next = dlgl_pkg::S_CHECK;
        end
      end
      dlgl_pkg::S_CHECK: begin
        if (rect_ok && (count_next != '0)) begin
          state_next = dlgl_pkg::S_DIVC;
        end else begin
          state_next = dlgl_pkg::S_IDLE;
        end
      end
      dlgl_pkg::S_DIVC: begin
        if (cnt == 5'(dlgl_pkg::DIV_BITS - 1)) begin
          state_next = dlgl_pkg::S_PREP;
        end
      end
      dlgl_pkg::S_PREP: begin
        if (cell_q == '0) begin
          state_next = dlgl_pkg::S_IDLE;
        end else begin
          state_next = dlgl_pkg::S_DIVW;
        end
      end
      dlgl_pkg::S_DIVW: begin
        if (cnt == 5'(dlgl_pkg::DIV_BITS - 1)) begin
          state_next = dlgl_pkg::S_EMIT;
        end
      end
      dlgl_pkg::S_EMIT: begin
        if (emit_load && (remain == dlgl_pkg::COUNT_BITS'(1))) begin
          state_next = dlgl_pkg::S_IDLE;
        end
      end
      default: state_next = dlgl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widths  <= dlgl_pkg::WIDTHS_RESET;
      o_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        widths <= cfg_data;
      end
      if (emit_load) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dlgl_pkg::S_IDLE: begin
        nsr  <= s_axis_tdata[31:0];
        mind <= s_axis_tdata[37:32];
        rx   <= s_axis_tdata[53:38];
        ry   <= s_axis_tdata[69:54];
        rw   <= s_axis_tdata[85:70];
        rh   <= s_axis_tdata[101:86];
        col  <= s_axis_tdata[133:102];
        bcd  <= '0;
        cnt  <= '0;
        acc  <= '0;
        adv  <= '0;
      end
      dlgl_pkg::S_CONV: begin
        // Shift-and-add-3 conversion, one binary bit per cycle, MSB first.
        bcd <= {bcd_adj[4*dlgl_pkg::BCD_DIGITS-2:0], nsr[dlgl_pkg::NUM_BITS-1]};
        nsr <= {nsr[dlgl_pkg::NUM_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        // Glyph strip offsets and the widest glyph, one glyph per cycle.
        if (cnt < 5'(dlgl_pkg::NUM_GLYPHS)) begin
          offs[cnt[3:0]] <= acc;
          acc            <= acc + dlgl_pkg::SRCX_BITS'(gw_sel);
          if (gw_sel > adv) begin
            adv <= gw_sel;
          end
        end
      end
      dlgl_pkg::S_CHECK: begin
        count <= count_next;
        cnt   <= '0;
      end
      dlgl_pkg::S_DIVC: begin
        cnt <= cnt + 1'b1;
      end
      dlgl_pkg::S_PREP: begin
        cell_w <= cell_q;
        remain <= count;
        cnt    <= '0;
      end
      dlgl_pkg::S_DIVW: begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd0) begin
          left <= {rx[15], rx} + dlgl_pkg::POS_BITS'(left_off);
        end
      end
      dlgl_pkg::S_EMIT: begin
        if (emit_load) begin
          o_src_x <= offs[digit];
          o_src_w <= gw_sel;
          o_dst_x <= left + dlgl_pkg::POS_BITS'(spare[dlgl_pkg::CELL_BITS-1:1]);
          o_dst_y <= ry;
          o_dst_w <= dw_sel;
          o_dst_h <= rh[dlgl_pkg::CELL_BITS-1:0];
          o_color <= col;
          o_last  <= (remain == dlgl_pkg::COUNT_BITS'(1));
          left    <= left - dlgl_pkg::POS_BITS'(cell_w);
          bcd     <= {4'd0, bcd[4*dlgl_pkg::BCD_DIGITS-1:4]};
          remain  <= remain - 1'b1;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire
